>>> rtl/mpcm_pkg.sv
// Package for the PCM sample mixer: action codes, controller states,
// command struct and default sizes. No dependencies.
package mpcm_pkg;

	localparam int VOICES_DEF = 12;
	localparam int SOUNDS_DEF = 128;
	localparam int SAMPLE_ADDR_BITS_DEF = 16;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_START  = 3'd1,
		ACT_STOP   = 3'd2,
		ACT_ENDLP  = 3'd3,
		ACT_GAIN   = 3'd4,
		ACT_WRITE  = 3'd5,
		ACT_DEFINE = 3'd6,
		ACT_QUERY  = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MIX   = 2'd1,
		ST_DRAIN = 2'd2,
		ST_DONE  = 2'd3
	} state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic clear_acc;
		logic load_imm;
		logic load_mix;
	} cmd_t;

endpackage

>>> rtl/mpcm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mpcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/mpcm_ctrl.sv
// Controller of the PCM mixer: transaction handshake, tick sequencing,
// output valid. Depends on mpcm_pkg.
module mpcm_ctrl #(
	parameter int VOICES = mpcm_pkg::VOICES_DEF,
	localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_tick,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mpcm_pkg::cmd_t  cmd,
	output logic [VB-1:0]   idx
);
	mpcm_pkg::state_t state_q, state_d;
	logic [VB-1:0] cnt_q, cnt_d;
	logic [1:0]    dcnt_q, dcnt_d;
	logic          ovalid_q;
	logic          slot_free;

	assign slot_free = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign idx = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mpcm_pkg::ST_IDLE;
			cnt_q    <= '0;
			dcnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			dcnt_q  <= dcnt_d;
			if (cmd.load_imm || cmd.load_mix) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		dcnt_d   = dcnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			mpcm_pkg::ST_IDLE: begin
				in_ready   = in_tick || slot_free;
				cmd.accept = in_valid && in_ready;
				if (cmd.accept) begin
					if (in_tick) begin
						cmd.clear_acc = 1'b1;
						cnt_d   = '0;
						state_d = mpcm_pkg::ST_MIX;
					end else begin
						cmd.load_imm = 1'b1;
					end
				end
			end
			mpcm_pkg::ST_MIX: begin
				cmd.issue = 1'b1;
				if (cnt_q == VB'(VOICES - 1)) begin
					dcnt_d  = '0;
					state_d = mpcm_pkg::ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mpcm_pkg::ST_DRAIN: begin
				dcnt_d = dcnt_q + 1'b1;
				if (dcnt_q == 2'd2) begin
					state_d = mpcm_pkg::ST_DONE;
				end
			end
			mpcm_pkg::ST_DONE: begin
				if (slot_free) begin
					cmd.load_mix = 1'b1;
					state_d = mpcm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mpcm_pkg::ST_IDLE;
			end
		endcase
	end
endmodule

>>> rtl/mpcm_datapath.sv
// Datapath of the PCM mixer: voice state, sound table, sample memory,
// mix pipeline and result register. Depends on mpcm_pkg and mpcm_ram.
module mpcm_datapath #(
	parameter int VOICES = mpcm_pkg::VOICES_DEF,
	parameter int SOUNDS = mpcm_pkg::SOUNDS_DEF,
	parameter int SAMPLE_ADDR_BITS = mpcm_pkg::SAMPLE_ADDR_BITS_DEF,
	localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpcm_pkg::cmd_t       cmd,
	input  logic [VB-1:0]        idx,
	input  mpcm_pkg::action_t    action,
	input  logic [3:0]           voice,
	input  logic [6:0]           sound_index,
	input  logic                 loop_enable,
	input  logic [16:0]          gain,
	input  logic [15:0]          address,
	input  logic [15:0]          word_data,
	input  logic [16:0]          sample_count,
	input  logic                 eight_bit,
	output logic signed [15:0]   mixed_sample,
	output logic                 playing,
	output logic                 status
);
	localparam int SB    = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
	localparam int SAB   = SAMPLE_ADDR_BITS;
	localparam int ACC_W = 18 + VB;
	localparam logic signed [ACC_W-1:0] MIX_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] MIX_MIN = -ACC_W'(32768);

	logic          active_q  [VOICES];
	logic          looping_q [VOICES];
	logic [SB-1:0] sound_q   [VOICES];
	logic [16:0]   pos_q     [VOICES];
	logic [16:0]   gain_q    [VOICES];

	logic [SB-1:0] snd_mod [128];
	for (genvar i = 0; i < 128; i++) begin : g_mod
		assign snd_mod[i] = SB'(i % SOUNDS);
	end

	logic          vok;
	logic [VB-1:0] vidx;
	logic          cur_active;
	assign vok  = {2'b00, voice} < 6'(VOICES);
	assign vidx = VB'(voice);
	assign cur_active = vok && active_q[vidx];

	// sound table: {eight, count, base}
	logic          snd_we;
	logic [33:0]   snd_rdata;
	assign snd_we = cmd.accept && action == mpcm_pkg::ACT_DEFINE
		&& 9'(sound_index) < 9'(SOUNDS);

	mpcm_ram #(.WIDTH(34), .DEPTH(SOUNDS)) u_snd (
		.clk   (clk),
		.we    (snd_we),
		.waddr (SB'(sound_index)),
		.wdata ({eight_bit, sample_count, address}),
		.raddr (sound_q[idx]),
		.rdata (snd_rdata)
	);

	// stage 1
	logic [VB-1:0] v_s1;
	logic          act_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= cmd.issue && active_q[idx];
		end
	end
	always_ff @(posedge clk) begin
		v_s1 <= idx;
	end

	// stage 2: end check, position update, sample fetch
	logic [16:0]    pos;
	logic           at_end, stop_now, play;
	logic [16:0]    p0;
	logic [SAB-1:0] mem_raddr;
	logic [15:0]    mem_rdata;
	assign pos      = pos_q[v_s1];
	assign at_end   = pos >= snd_rdata[32:16];
	assign stop_now = act_s1 && at_end && !looping_q[v_s1];
	assign play     = act_s1 && !stop_now;
	assign p0       = at_end ? 17'd0 : pos;
	assign mem_raddr = SAB'({2'b00, snd_rdata[15:0]} + {1'b0, p0});

	mpcm_ram #(.WIDTH(16), .DEPTH(2 ** SAB)) u_mem (
		.clk   (clk),
		.we    (cmd.accept && action == mpcm_pkg::ACT_WRITE),
		.waddr (SAB'(address)),
		.wdata (word_data),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	logic        play_s2, eight_s2;
	logic [16:0] gain_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_s2 <= 1'b0;
		end else begin
			play_s2 <= play;
		end
	end
	always_ff @(posedge clk) begin
		eight_s2 <= snd_rdata[33];
		gain_s2  <= gain_q[v_s1];
	end

	// stage 3: scale
	logic signed [15:0] smp;
	logic signed [33:0] prod_s3;
	logic               play_s3;
	assign smp = eight_s2 ? {~mem_rdata[7], mem_rdata[6:0], 8'h00} : mem_rdata;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_s3 <= 1'b0;
		end else begin
			play_s3 <= play_s2;
		end
	end
	always_ff @(posedge clk) begin
		prod_s3 <= 34'(smp * $signed({1'b0, gain_s2}));
	end

	// stage 4: truncate toward zero, floor halve, accumulate
	logic signed [17:0]      q;
	logic signed [16:0]      term;
	logic signed [ACC_W-1:0] acc_q;
	assign q    = prod_s3[33:16] + 18'((prod_s3[33] && |prod_s3[15:0]) ? 1 : 0);
	assign term = q[17:1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.clear_acc) begin
			acc_q <= '0;
		end else if (play_s3) begin
			acc_q <= acc_q + ACC_W'(term);
		end
	end

	// voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				active_q[v]  <= 1'b0;
				looping_q[v] <= 1'b0;
				sound_q[v]   <= '0;
				pos_q[v]     <= '0;
				gain_q[v]    <= 17'h10000;
			end
		end else begin
			if (cmd.accept && vok) begin
				case (action)
					mpcm_pkg::ACT_START: begin
						if (!active_q[vidx]) begin
							active_q[vidx]  <= 1'b1;
							sound_q[vidx]   <= snd_mod[sound_index];
							looping_q[vidx] <= loop_enable;
							pos_q[vidx]     <= '0;
						end
					end
					mpcm_pkg::ACT_STOP: begin
						active_q[vidx]  <= 1'b0;
						looping_q[vidx] <= 1'b0;
						pos_q[vidx]     <= '0;
					end
					mpcm_pkg::ACT_ENDLP: begin
						looping_q[vidx] <= 1'b0;
					end
					mpcm_pkg::ACT_GAIN: begin
						gain_q[vidx] <= gain;
					end
					default: begin
					end
				endcase
			end
			if (act_s1) begin
				if (stop_now) begin
					active_q[v_s1] <= 1'b0;
					pos_q[v_s1]    <= '0;
				end else begin
					pos_q[v_s1] <= p0 + 17'd1;
				end
			end
		end
	end

	// result register
	logic signed [15:0] sat;
	always_comb begin
		if (acc_q > MIX_MAX) begin
			sat = 16'sh7fff;
		end else if (acc_q < MIX_MIN) begin
			sat = -16'sh8000;
		end else begin
			sat = acc_q[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_imm) begin
			mixed_sample <= '0;
			playing      <= action == mpcm_pkg::ACT_QUERY && cur_active;
			status       <= action == mpcm_pkg::ACT_START && cur_active;
		end else if (cmd.load_mix) begin
			mixed_sample <= sat;
			playing      <= 1'b0;
			status       <= 1'b0;
		end
	end
endmodule

>>> rtl/multichannel_pcm_sample_mixer_core.sv
// Top level of the 12-voice PCM sample mixer with saturation.
// Depends on mpcm_pkg, mpcm_ctrl, mpcm_datapath.
//
//  port group  dir  tdata fields (low bit up)                    tuser
//  s_*         in   voice, sound_index, loop_enable, gain,       action
//                   address, word_data, sample_count, eight_bit
//  m_*         out  mixed_sample, playing, status                 -
//
// A tick runs one voice per cycle through a four-stage fetch/scale/accumulate
// pipeline; no new transaction is accepted until the tick's result is loaded.
// Every other action loads its result straight into the output register.
// Reset clears voice state; sound table and sample memory are not cleared.
// A finished result waits in the output register while the next transaction
// is accepted; a stalled output holds the block only when it must load again.
module multichannel_pcm_sample_mixer_core #(
	parameter int VOICES = mpcm_pkg::VOICES_DEF,
	parameter int SOUNDS = mpcm_pkg::SOUNDS_DEF,
	parameter int SAMPLE_ADDR_BITS = mpcm_pkg::SAMPLE_ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // voice, sound_index, loop_enable, gain, address,
	                              // word_data, sample_count, eight_bit, pad
	input  logic [2:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // mixed_sample, playing, status, pad
);
	localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1;

	mpcm_pkg::cmd_t     cmd;
	logic [VB-1:0]      idx;
	mpcm_pkg::action_t  action;
	logic signed [15:0] mixed_sample;
	logic               playing, status;

	assign action = mpcm_pkg::action_t'(s_tuser);

	mpcm_ctrl #(.VOICES(VOICES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_tick   (action == mpcm_pkg::ACT_TICK),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.idx       (idx)
	);

	mpcm_datapath #(
		.VOICES           (VOICES),
		.SOUNDS           (SOUNDS),
		.SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.idx          (idx),
		.action       (action),
		.voice        (s_tdata[3:0]),
		.sound_index  (s_tdata[10:4]),
		.loop_enable  (s_tdata[11]),
		.gain         (s_tdata[28:12]),
		.address      (s_tdata[44:29]),
		.word_data    (s_tdata[60:45]),
		.sample_count (s_tdata[77:61]),
		.eight_bit    (s_tdata[78]),
		.mixed_sample (mixed_sample),
		.playing      (playing),
		.status       (status)
	);

	assign m_tdata = {6'd0, status, playing, mixed_sample};

`ifndef SYNTHESIS
	a_tick_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == mpcm_pkg::ACT_TICK |=> !$rose(m_tvalid))
		else $error("tick result appeared too early");
	a_imm_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != mpcm_pkg::ACT_TICK |=> m_tvalid)
		else $error("immediate result missing");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tvalid && !m_tready |-> s_tuser == mpcm_pkg::ACT_TICK)
		else $error("pending result would be overwritten");
`endif
endmodule
